FILE: src/crc_framed_blob_checker_defines.svh
// Assertion macros used by the checker file of the framed blob checker.
`ifndef CRC_FRAMED_BLOB_CHECKER_DEFINES_SVH
`define CRC_FRAMED_BLOB_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and quiet during reset.
`define CFBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfbc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock and quiet during reset.
`define CFBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfbc: next-cycle check failed");

`endif

FILE: src/cfbc_pkg.sv
// Types, constants and the CRC byte update for the framed blob checker.
`timescale 1ns / 1ps
`default_nettype none
package cfbc_pkg;

   localparam logic [31:0] MAGIC_WORD   = 32'h434E4647;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
   localparam int          HDR_BYTES    = 16;
   localparam int          MIN_BYTES    = 4;
   localparam int          MIN_HDR_BLOB = HDR_BYTES + 4;
   localparam logic [29:0] FCOUNT_MAX   = 30'h3FFFFFFF;
   localparam logic [31:0] VERSION_INIT = 32'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        too_short;
      logic        has_header;
      logic        version_mismatch;
      logic        count_mismatch;
      logic        crc_mismatch;
      logic [29:0] float_count;
      logic [31:0] computed_crc;
   } rsp_type;

   // Reflected CRC-32 update by one byte, unrolled over its eight bits.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_cur,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: src/crc_framed_blob_checker.sv
// Top level of the framed blob checker: header capture, CRC-32 and status.
`timescale 1ns / 1ps
`default_nettype none
// The checker takes a blob one byte per item on the req channel, with
// last_byte set on the final byte, and returns exactly one status item on the
// rsp channel for each blob, at its last byte. The first 16 bytes are held as
// a header (magic, version, float count, CRC; little-endian words) and a
// reflected CRC-32 runs over every byte after them. An item is taken every
// cycle while req_ready is high: the header capture, the byte-wide CRC
// update and the status decode all sit between the input port and one result
// register, so the status appears in the cycle after the last byte is taken.
// req_ready is high whenever the result register is empty or is being
// emptied in the same cycle, so a stalled rsp side holds back only the next
// byte. The expected version register is written on the csr channel, which
// is always ready; it should be written only between blobs. The byte counter
// is COUNT_WIDTH bits wide and saturates, while the CRC keeps taking bytes.
module crc_framed_blob_checker #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  cfbc_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output cfbc_pkg::rsp_type     rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [31:0]            csr_data
);
   import cfbc_pkg::*;

   // Payload counts are compared at least 32 bits wide, wider if the float count is.
   localparam int FC_W  = COUNT_WIDTH - 2;
   localparam int CMP_W = (FC_W > 32) ? FC_W : 32;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            crc_ff, crc_in;
   logic [7:0]             header_ff [HDR_BYTES];
   logic [31:0]            expected_version_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   in_header;
   logic [31:0]            crc_step;
   logic [31:0]            hdr_magic, hdr_version, hdr_count, hdr_crc;
   logic [COUNT_WIDTH-1:0] total;
   logic                   is_short, is_framed;
   logic [FC_W-1:0]        fc;
   logic [CMP_W-1:0]       fc_wide;
   logic [31:0]            crc_final;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Header words, little-endian in file order.
   assign hdr_magic   = {header_ff[3],  header_ff[2],  header_ff[1],  header_ff[0]};
   assign hdr_version = {header_ff[7],  header_ff[6],  header_ff[5],  header_ff[4]};
   assign hdr_count   = {header_ff[11], header_ff[10], header_ff[9],  header_ff[8]};
   assign hdr_crc     = {header_ff[15], header_ff[14], header_ff[13], header_ff[12]};

   // Bytes before position 16 go to the header, later ones to the CRC.
   assign in_header = count_ff < COUNT_WIDTH'(HDR_BYTES);
   assign crc_step  = crc_byte(crc_ff, req_data.data_byte);

   always_comb begin
      count_in = (&count_ff) ? count_ff : count_ff + COUNT_WIDTH'(1);
      crc_in   = in_header ? crc_ff : crc_step;
   end

   // Status decode, using the state as it stands after the last byte. A framed
   // blob has at least 20 bytes, so its header is complete before the last
   // byte and the header store alone is read here.
   always_comb begin
      total     = count_in;
      crc_final = ~crc_in;
      is_short  = total < COUNT_WIDTH'(MIN_BYTES);
      is_framed = (total >= COUNT_WIDTH'(MIN_HDR_BLOB)) && (hdr_magic == MAGIC_WORD);
      if (is_framed) begin
         fc = FC_W'((total - COUNT_WIDTH'(HDR_BYTES)) >> 2);
      end else begin
         fc = FC_W'(total >> 2);
      end
      fc_wide = CMP_W'(fc);

      rsp_data_in = '0;
      if (is_short) begin
         rsp_data_in.too_short = 1'b1;
      end else begin
         if (fc_wide > CMP_W'(FCOUNT_MAX)) begin
            rsp_data_in.float_count = FCOUNT_MAX;
         end else begin
            rsp_data_in.float_count = fc_wide[29:0];
         end
         if (is_framed) begin
            rsp_data_in.has_header       = 1'b1;
            rsp_data_in.version_mismatch = hdr_version != expected_version_ff;
            rsp_data_in.count_mismatch   = fc_wide != CMP_W'(hdr_count);
            rsp_data_in.crc_mismatch     = crc_final != hdr_crc;
            rsp_data_in.computed_crc     = crc_final;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Blob state: cleared after the last byte so the next blob starts fresh.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_data.last_byte) begin
               count_ff <= '0;
               crc_ff   <= CRC_INIT;
            end else begin
               count_ff <= count_in;
               crc_ff   <= crc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= VERSION_INIT;
      end else if (csr_valid && csr_ready) begin
         expected_version_ff <= csr_data;
      end
   end

   // Header bytes are read only once all 16 have been written for the blob.
   always_ff @(posedge clock) begin
      if (accept && in_header) begin
         header_ff[count_ff[3:0]] <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/cfbc_checker.sv
// Port-level assertions for the framed blob checker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "crc_framed_blob_checker_defines.svh"
module cfbc_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input cfbc_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input cfbc_pkg::rsp_type rsp_data
);
   import cfbc_pkg::*;

   logic rsp_stall;
   logic mid_byte;
   logic short_clean;
   logic legacy_clean;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign mid_byte     = req_valid && req_ready && !req_data.last_byte;
   assign short_clean  = !rsp_data.has_header && (rsp_data.float_count == 30'd0)
                         && (rsp_data.computed_crc == 32'd0);
   assign legacy_clean = !rsp_data.version_mismatch && !rsp_data.count_mismatch
                         && !rsp_data.crc_mismatch && (rsp_data.computed_crc == 32'd0);

   // A status waiting on a stalled sink stays put.
   `CFBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // A byte that is not the last one never creates a status.
   `CFBC_ASSERT_NEXT(a_no_status_midblob, clock, reset, mid_byte && !rsp_valid, !rsp_valid)

   // A short blob reports nothing but the short flag.
   `CFBC_ASSERT_IMPL(a_short_clean, clock, reset, rsp_valid && rsp_data.too_short, short_clean)

   // Header checks and the CRC appear only for a framed blob.
   `CFBC_ASSERT_IMPL(a_legacy_clean, clock, reset, rsp_valid && !rsp_data.has_header, legacy_clean)

endmodule

bind crc_framed_blob_checker cfbc_checker u_cfbc_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_crc_framed_blob_checker.sv
// Self-checking testbench for the framed blob checker with header and CRC-32 status.
`timescale 1ns / 1ps
module tb_crc_framed_blob_checker;
   import cfbc_pkg::*;

   // The status item is registered after the last byte. The settle wait
   // gives margin before a register write or the end of the run.
   localparam int SETTLE_CYCLES = 4;
   // Limit on the run length, used by the watchdog.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LINES  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   crc_framed_blob_checker #(
      .COUNT_WIDTH(32)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #2 clock = ~clock;

   // Predictor state. It holds its own copy of the header bytes, the byte
   // count, the running CRC and the version register.
   logic [7:0]  hdr_bytes [16];
   logic [31:0] blob_len;
   logic [31:0] crc_run;
   logic [31:0] version_model;

   // Status items predicted but not yet seen on the rsp channel, oldest first.
   rsp_type     pending_status [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // Stimulus controls. Sender gaps and receiver stalls can be switched on
   // and off between phases.
   bit          gaps_on;
   bit          stall_on;
   int          burst_left;
   logic [15:0] rx_pattern;
   logic [3:0]  rx_idx;

   // The blob that is built next and then sent byte by byte.
   logic [7:0]  blob_bytes [$];

   // One step of the reflected CRC-32. It is written bit-serially: each input
   // bit is folded into the feedback as the register shifts right.
   function automatic logic [31:0] crc32_step(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
      logic [31:0] c;
      logic        fb;
      c = crc_in;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ data[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // The header is read as little-endian 32-bit words.
   function automatic logic [31:0] hdr_word(input int at);
      return {hdr_bytes[at + 3], hdr_bytes[at + 2], hdr_bytes[at + 1], hdr_bytes[at]};
   endfunction

   task automatic clear_blob_model();
      foreach (hdr_bytes[i]) begin
         hdr_bytes[i] = 8'h00;
      end
      blob_len = '0;
      crc_run  = CRC_INIT;
   endtask

   // Applies one accepted byte to the predictor. On the last byte of a blob
   // it decodes the status, queues it and clears the per-blob state.
   task automatic predict_blob_byte(input req_type it);
      rsp_type     st;
      logic [31:0] payload_floats;
      logic [31:0] crc_final;
      if (blob_len < HDR_BYTES) begin
         hdr_bytes[blob_len[3:0]] = it.data_byte;
      end else begin
         crc_run = crc32_step(crc_run, it.data_byte);
      end
      // The byte counter saturates, but the CRC still takes every byte.
      if (blob_len != '1) begin
         blob_len = blob_len + 1;
      end
      if (it.last_byte) begin
         st = '0;
         if (blob_len < MIN_BYTES) begin
            st.too_short = 1'b1;
         end else if (blob_len >= MIN_HDR_BLOB && hdr_word(0) == MAGIC_WORD) begin
            crc_final           = ~crc_run;
            payload_floats      = (blob_len - HDR_BYTES) >> 2;
            st.has_header       = 1'b1;
            st.version_mismatch = (hdr_word(4) != version_model);
            st.count_mismatch   = (payload_floats != hdr_word(8));
            st.crc_mismatch     = (crc_final != hdr_word(12));
            st.float_count      = (payload_floats > FCOUNT_MAX) ?
                                  FCOUNT_MAX : payload_floats[29:0];
            st.computed_crc     = crc_final;
         end else begin
            // Legacy raw stream: whole words counted over the full length.
            payload_floats = blob_len >> 2;
            st.float_count = (payload_floats > FCOUNT_MAX) ?
                             FCOUNT_MAX : payload_floats[29:0];
         end
         pending_status.push_back(st);
         clear_blob_model();
      end
   endtask

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("[%0t] MISMATCH %s", $realtime, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s: got %h, expected %h", name, got, want));
      end
   endtask

   // Sends one byte as an item. With gaps on, the sender idles for a random gap
   // between bursts of random length. Valid is raised at a falling edge and
   // held until a rising edge where ready is seen high.
   task automatic send_byte(input logic [7:0] data, input bit last);
      req_type it;
      int      gap;
      it.data_byte = data;
      it.last_byte = last;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 32);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_blob_byte(it);
   endtask

   task automatic send_blob();
      for (int i = 0; i < blob_bytes.size(); i++) begin
         send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
      end
   endtask

   // Drops valid, then waits until every predicted status item has arrived and
   // the block has had time to settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the expected version register. This happens only when the block is idle.
   task automatic set_expected_version(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      version_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic append_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) begin
         blob_bytes.push_back(w[8 * i +: 8]);
      end
   endtask

   // Builds a framed blob with a random payload. The flip masks corrupt the
   // magic, the float count or the CRC word of the header. A zero mask keeps
   // that word correct.
   task automatic build_framed_blob(input logic [31:0] version, input int payload_len,
                                    input logic [31:0] magic_flip,
                                    input logic [31:0] count_flip,
                                    input logic [31:0] crc_flip);
      logic [7:0]  payload [$];
      logic [7:0]  b;
      logic [31:0] crc;
      logic [31:0] floats;
      crc = CRC_INIT;
      for (int i = 0; i < payload_len; i++) begin
         b = 8'($urandom);
         payload.push_back(b);
         crc = crc32_step(crc, b);
      end
      floats = payload_len / 4;
      blob_bytes.delete();
      append_word(MAGIC_WORD ^ magic_flip);
      append_word(version);
      append_word(floats ^ count_flip);
      append_word(~crc ^ crc_flip);
      foreach (payload[i]) begin
         blob_bytes.push_back(payload[i]);
      end
   endtask

   // Mask with a single random bit set in most cases, and a random word otherwise.
   function automatic logic [31:0] random_flip();
      logic [31:0] m;
      if ($urandom_range(0, 3) != 0) begin
         m = 32'd1 << $urandom_range(0, 31);
      end else begin
         m = $urandom | 32'd1;
      end
      return m;
   endfunction

   // Blobs of one, two and three bytes are too short. The extreme byte
   // values go in here, and every non-final byte must give no status item.
   task automatic test_too_short();
      blob_bytes = '{8'hFF};
      send_blob();
      blob_bytes = '{8'h00, 8'hFF};
      send_blob();
      blob_bytes = '{8'h80, 8'h7F, 8'h01};
      send_blob();
      wait_idle();
   endtask

   // Four bytes is the shortest legacy stream. Its float count is one.
   task automatic test_legacy_minimum();
      blob_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      send_blob();
      wait_idle();
   endtask

   // This is the shortest framed blob that is taken as a header: a clean header and
   // one float of payload. It runs with the version register at its reset value.
   task automatic test_header_minimum();
      build_framed_blob(VERSION_INIT, 4, '0, '0, '0);
      send_blob();
      wait_idle();
   endtask

   // Random mix of blobs. Most are framed blobs with random
   // payloads. Some carry a bad version, count or CRC. The rest are broken
   // magic words, short headers, legacy streams and too-short blobs.
   task automatic test_random_blobs(input int byte_budget);
      int          sent;
      int          kind;
      int          plen;
      logic [31:0] ver;
      logic [31:0] mflip;
      logic [31:0] kflip;
      logic [31:0] cflip;
      sent = 0;
      while (sent < byte_budget) begin
         kind = $urandom_range(0, 99);
         blob_bytes.delete();
         if (kind < 8) begin
            repeat ($urandom_range(1, 3)) blob_bytes.push_back(8'($urandom));
         end else if (kind < 20) begin
            repeat ($urandom_range(4, 48)) blob_bytes.push_back(8'($urandom));
         end else begin
            // Most payloads are short. A few are long, and a payload of zero
            // to three bytes leaves the blob too short to use its header.
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 160) :
                                                 $urandom_range(0, 48);
            case ($urandom_range(0, 9))
               7: begin
                  ver = $urandom;
               end
               8, 9: begin
                  ver = version_model ^ (32'd1 << $urandom_range(0, 31));
               end
               default: begin
                  ver = version_model;
               end
            endcase
            mflip = (kind < 30) ? random_flip() : '0;
            kflip = ($urandom_range(0, 4) == 0) ? random_flip() : '0;
            cflip = ($urandom_range(0, 4) == 0) ? random_flip() : '0;
            build_framed_blob(ver, plen, mflip, kflip, cflip);
         end
         sent += blob_bytes.size();
         send_blob();
      end
      wait_idle();
   endtask

   // Receiver stalls follow a 16-bit pattern that is drawn again each time
   // it wraps. The pattern can be all ready, random bits, mostly ready, or a
   // long stall run.
   always @(negedge clock) begin
      if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else begin
         if (rx_idx == 4'd0) begin
            case ($urandom_range(0, 3))
               0: begin
                  rx_pattern = '1;
               end
               1: begin
                  rx_pattern = 16'($urandom);
               end
               2: begin
                  rx_pattern = 16'($urandom | $urandom);
               end
               default: begin
                  rx_pattern = ~(16'h00FF << $urandom_range(0, 8));
               end
            endcase
         end
         rsp_ready <= rx_pattern[rx_idx];
         rx_idx = rx_idx + 4'd1;
      end
   end

   // Each status item taken by the receiver is checked against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            report_error("status item with none expected");
         end else begin
            want = pending_status.pop_front();
            compare_field("too_short", rsp_data.too_short, want.too_short);
            compare_field("has_header", rsp_data.has_header, want.has_header);
            compare_field("version_mismatch", rsp_data.version_mismatch,
                          want.version_mismatch);
            compare_field("count_mismatch", rsp_data.count_mismatch,
                          want.count_mismatch);
            compare_field("crc_mismatch", rsp_data.crc_mismatch, want.crc_mismatch);
            compare_field("float_count", rsp_data.float_count, want.float_count);
            compare_field("computed_crc", rsp_data.computed_crc, want.computed_crc);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      gaps_on    = 1'b0;
      stall_on   = 1'b0;
      burst_left = 0;
      rx_pattern = '1;
      rx_idx     = 4'd0;
      version_model = VERSION_INIT;
      clear_blob_model();

      // Synchronous reset, held high from the start and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases run one after another; each ends by waiting until the
      // block is idle, while the blobs within a case are sent back to back.
      test_too_short();
      test_legacy_minimum();
      test_header_minimum();

      // Random phases. The phases run with several version settings, including
      // both extremes, and with every mix of sender gaps and receiver stalls.
      test_random_blobs(330);
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      set_expected_version(32'h0000_0000);
      test_random_blobs(330);
      stall_on = 1'b0;
      set_expected_version(32'hFFFF_FFFF);
      test_random_blobs(330);
      gaps_on  = 1'b0;
      stall_on = 1'b1;
      set_expected_version($urandom);
      test_random_blobs(330);
      gaps_on  = 1'b1;
      set_expected_version(VERSION_INIT);
      test_random_blobs(330);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
